// ===== rtl/cms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Count-min sketch package
// Shared constants, types and opcodes for the sketch engine.
// ----------------------------------------------------------------------------
package cms_pkg;
    localparam int MaxRows    = 16;
    localparam int MaxColumns = 2048;
    localparam int RowW       = $clog2(MaxRows);
    localparam int ColW       = $clog2(MaxColumns);
    localparam int AddrW      = RowW + ColW;
    localparam int Depth      = MaxRows * MaxColumns;
    // one remainder step per bit of the masked hash
    localparam int ModSteps    = 31;
    // cycles from request acceptance until every cell has its column
    localparam int ChainCycles = MaxRows + ModSteps + 1;

    localparam logic [11:0] WidthReset = 12'd2000;
    localparam logic [4:0]  DepthReset = 5'd10;
    localparam logic [30:0] HashMask   = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        t_op_update = 2'd0,
        t_op_query  = 2'd1,
        t_op_load   = 2'd2,
        t_op_none   = 2'd3
    } t_op;

    // request travelling down the cell chain
    typedef struct packed {
        logic        vld;
        logic [1:0]  op;
        logic [31:0] hash;
        logic [31:0] amount;
        logic [3:0]  row_index;
        logic [30:0] coef_a;
        logic [30:0] coef_b;
    } t_req;
endpackage
`default_nettype wire

// ===== rtl/cms_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sketch channels
// Valid/ready request and result channels.
// ----------------------------------------------------------------------------
interface cms_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] item_hash;
    logic signed [31:0] amount;
    logic [3:0]  row_index;
    logic [30:0] coef_a;
    logic [30:0] coef_b;
    modport source (output valid, op, item_hash, amount, row_index, coef_a, coef_b,
                    input ready);
    modport sink (input valid, op, item_hash, amount, row_index, coef_a, coef_b,
                  output ready);
endinterface

interface cms_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] estimate;
    logic signed [63:0] total_count;
    logic        saturated;
    modport source (output valid, estimate, total_count, saturated, input ready);
    modport sink (input valid, estimate, total_count, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/cms_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module cms_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/cms_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sketch row cell
// Holds one row's coefficients and computes that row's column index.
// ----------------------------------------------------------------------------
module cms_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [3:0]      i_row,
    input  wire cms_pkg::t_req   i_req,
    output cms_pkg::t_req        o_req,
    input  wire logic [11:0]     i_width,
    output logic [cms_pkg::ColW-1:0] o_col,
    output logic                 o_col_vld
);
    import cms_pkg::*;

    logic [30:0] r_a, r_b;
    logic [31:0] r_prod;
    logic [30:0] r_h;
    logic [ColW-1:0] r_rem;
    logic [4:0]  r_step;
    logic [1:0]  r_phase;
    logic        r_busy;
    logic [30:0] w_h;
    logic [ColW:0]   w_trial;
    logic [ColW-1:0] w_rem;
    logic        w_start;
    logic        w_last;

    assign w_h = 31'(r_prod + {1'b0, r_b}) & HashMask;

    // shift the next hash bit into the partial remainder and reduce it once
    assign w_trial = {r_rem, r_h[30]};
    assign w_rem   = (w_trial >= i_width) ? ColW'(w_trial - i_width) : ColW'(w_trial);

    assign w_start = i_req.vld && (i_req.op == t_op_update || i_req.op == t_op_query);
    assign w_last  = !w_start && r_busy && (r_phase == 2'd1) && (r_step == 5'd0);

    // load coefficients, compute hash, reduce it bit by bit, pass request on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a       <= '0;
            r_b       <= '0;
            o_req.vld <= 1'b0;
            o_col_vld <= 1'b0;
            r_busy    <= 1'b0;
            r_phase   <= '0;
        end else begin
            o_req     <= i_req;
            o_col_vld <= w_last;
            if (i_req.vld && i_req.op == t_op_load && i_req.row_index == i_row) begin
                r_a <= i_req.coef_a;
                r_b <= i_req.coef_b;
            end
            if (w_start) begin
                r_prod  <= 32'({1'b0, r_a} * i_req.hash);
                r_busy  <= 1'b1;
                r_phase <= 2'd0;
            end else if (r_busy) begin
                if (r_phase == 2'd0) begin
                    r_h     <= w_h;
                    r_rem   <= '0;
                    r_step  <= 5'(ModSteps - 1);
                    r_phase <= 2'd1;
                end else begin
                    r_h    <= r_h << 1;
                    r_rem  <= w_rem;
                    r_step <= r_step - 1'b1;
                    if (r_step == 5'd0) begin
                        o_col  <= w_rem;
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/count_min_sketch_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Count-min sketch engine
// Chain of row cells feeding a shared counter store.
// ----------------------------------------------------------------------------
// Usage: requests enter on i_req (op, item_hash, amount, row_index, coef_a,
// coef_b); one result per request leaves on o_res (estimate, total_count,
// saturated). The APB port writes width_in_use at 0x0 and depth_in_use at 0x4.
// A request is taken only while the engine is idle. It walks a chain of 16
// row cells, one cell a cycle; each cell reduces its hash modulo the width one
// bit a cycle, so the columns are ready once the last cell has finished.
// Then each active row's counter is read through the counter RAM port in
// states S_RD, S_WAIT and S_WR; an update adds its amount, saturating, and
// writes the sum back. Load and no-op requests skip the counter pass. A new
// request is taken only after the previous result has been accepted.
// After reset a clearing pass writes zero through all 32768 counters, one
// per cycle; no request is taken until the pass is done.
// A stalled result holds in the output register; the next request waits.
// ----------------------------------------------------------------------------
module count_min_sketch_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    cms_in_if.sink           i_req,
    cms_out_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import cms_pkg::*;

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_CHAIN, S_RD, S_WAIT, S_WR, S_OUT} t_state;
    t_state r_state;

    logic [11:0] r_width;
    logic [4:0]  r_depth;
    logic [11:0] w_width;
    logic [4:0]  w_depth;
    t_req        w_chain [MaxRows+1];
    logic [ColW-1:0] w_col [MaxRows];
    logic [MaxRows-1:0] w_col_vld;
    logic [ColW-1:0] r_cols [MaxRows];
    logic [RowW:0]   r_row;
    logic [AddrW:0]  r_clr;
    logic [5:0]      r_cnt;
    t_req            r_item;
    logic signed [31:0] r_min;
    logic signed [63:0] r_total;
    logic        r_sat;
    logic        ram_we;
    logic [AddrW-1:0] ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata;
    logic signed [32:0] w_sum;
    logic signed [31:0] w_clip;
    logic        w_ovf;

    assign pready = 1'b1;
    assign prdata = (paddr[2]) ? {27'd0, r_depth} : {20'd0, r_width};
    assign w_width = (r_width == 12'd0) ? 12'd1 :
                     (r_width > 12'(MaxColumns)) ? 12'(MaxColumns) : r_width;
    assign w_depth = (r_depth == 5'd0) ? 5'd1 :
                     (r_depth > 5'(MaxRows)) ? 5'(MaxRows) : r_depth;

    assign w_chain[0].vld       = i_req.valid && i_req.ready;
    assign w_chain[0].op        = i_req.op;
    assign w_chain[0].hash      = i_req.item_hash;
    assign w_chain[0].amount    = i_req.amount;
    assign w_chain[0].row_index = i_req.row_index;
    assign w_chain[0].coef_a    = i_req.coef_a;
    assign w_chain[0].coef_b    = i_req.coef_b;

    // row cells
    for (genvar g = 0; g < MaxRows; g++) begin : g_cell
        cms_cell u_cell (
            .i_clk, .i_rst_n, .i_row(RowW'(g)), .i_req(w_chain[g]),
            .o_req(w_chain[g+1]), .i_width(w_width),
            .o_col(w_col[g]), .o_col_vld(w_col_vld[g])
        );
    end

    cms_ram #(.Width(32), .Depth(Depth)) u_ram (
        .i_clk, .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    assign ram_raddr = {r_row[RowW-1:0], r_cols[r_row[RowW-1:0]]};
    assign w_sum  = 33'(signed'(ram_rdata)) + 33'(signed'(r_item.amount));
    assign w_ovf  = w_sum[32] != w_sum[31];
    assign w_clip = w_ovf ? (w_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : w_sum[31:0];
    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_WR && r_item.op == t_op_update);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr[AddrW-1:0] : ram_raddr;
    assign ram_wdata = (r_state == S_CLEAR) ? 32'd0 : w_clip;

    assign i_req.ready = (r_state == S_IDLE);

    // capture column indices
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MaxRows; k++) begin
            if (w_col_vld[k]) r_cols[k] <= w_col[k];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_width     <= WidthReset;
            r_depth     <= DepthReset;
            r_total     <= '0;
            o_res.valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr == 3'd0) r_width <= pwdata[11:0];
                else if (paddr == 3'd4) r_depth <= pwdata[4:0];
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AddrW+1)'(Depth - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_item  <= w_chain[0];
                        r_cnt   <= '0;
                        r_state <= S_CHAIN;
                    end
                end
                S_CHAIN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(ChainCycles)) begin
                        r_row <= '0;
                        r_min <= 32'sh7FFF_FFFF;
                        r_sat <= 1'b0;
                        if (r_item.op == t_op_update) begin
                            r_total <= r_total + 64'(signed'(r_item.amount));
                        end
                        r_state <= (r_item.op == t_op_update || r_item.op == t_op_query)
                                   ? S_RD : S_OUT;
                    end
                end
                S_RD:   r_state <= S_WAIT;
                S_WAIT: r_state <= S_WR;
                S_WR: begin
                    if (signed'(ram_rdata) < r_min) r_min <= signed'(ram_rdata);
                    if (r_item.op == t_op_update && w_ovf) r_sat <= 1'b1;
                    r_row <= r_row + 1'b1;
                    r_state <= ((r_row + 1'b1) == (RowW+1)'(w_depth)) ? S_OUT : S_RD;
                end
                S_OUT: begin
                    if (!o_res.valid) begin
                        o_res.valid       <= 1'b1;
                        o_res.estimate    <= (r_item.op == t_op_query) ? r_min : 32'sd0;
                        o_res.total_count <= r_total;
                        o_res.saturated   <= (r_item.op == t_op_update) ? r_sat : 1'b0;
                    end else if (o_res.ready) begin
                        o_res.valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_res.valid) else $error("ready while result pending");
    a_no_we_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we) else $error("write while idle");
    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_row < (RowW+1)'(w_depth))) else $error("row overrun");
endmodule
`default_nettype wire
